@@ sv/sscu_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the stepper speed ramp controller.
// No dependencies; every other file refers to it by scoped names.
package sscu_pkg;

  localparam int unsigned CLK_W   = 25;
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned DEB_W   = 4;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned IDX_W   = 3;

  // Dividend is the clock shifted right by log2 of the prescale (at least 1).
  localparam int unsigned DVD_W     = CLK_W - 1;
  localparam int unsigned DIV_STEPS = DVD_W;
  localparam int unsigned DCNT_W    = $clog2(DIV_STEPS);

  localparam logic [SPEED_W-1:0] FAST_LIMIT   = SPEED_W'(255);
  localparam logic [7:0]         MAX_QUOTIENT = 8'd255;

  localparam logic [IDX_W-1:0] CFG_CLOCK_HZ   = IDX_W'(0);
  localparam logic [IDX_W-1:0] CFG_TRACK_SPD  = IDX_W'(1);
  localparam logic [IDX_W-1:0] CFG_REWIND_SPD = IDX_W'(2);
  localparam logic [IDX_W-1:0] CFG_RAMP_STEP  = IDX_W'(3);
  localparam logic [IDX_W-1:0] CFG_DEBOUNCE   = IDX_W'(4);

  localparam logic [CLK_W-1:0]   RST_CLOCK_HZ   = CLK_W'(1000000);
  localparam logic [SPEED_W-1:0] RST_TRACK_SPD  = SPEED_W'(76);
  localparam logic [SPEED_W-1:0] RST_REWIND_SPD = SPEED_W'(4000);
  localparam logic [SPEED_W-1:0] RST_RAMP_STEP  = SPEED_W'(40);
  localparam logic [DEB_W-1:0]   RST_DEBOUNCE   = DEB_W'(2);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic [CLK_W-1:0]   clock_hz;
    logic [SPEED_W-1:0] track_speed;
    logic [SPEED_W-1:0] rewind_speed;
    logic [SPEED_W-1:0] ramp_step;
    logic [DEB_W-1:0]   debounce_ticks;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic [DVD_W-1:0]   dividend;
    logic [SPEED_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               running;
    logic               range_fast;
    logic               dir;
    logic               mode_rewind;
  } status_t;

endpackage

@@ sv/sscu_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for button samples and result transactions.
// Depends on sscu_pkg for field widths.
interface sscu_in_if;
  logic valid;
  logic ready;
  logic track_level;
  logic rewind_level;

  modport source (output valid, output track_level, output rewind_level, input ready);
  modport sink   (input valid, input track_level, input rewind_level, output ready);
endinterface

interface sscu_out_if;
  logic                        valid;
  logic                        ready;
  logic [sscu_pkg::COUNT_W-1:0] period_count;
  logic                        step_running;
  logic                        fast_prescale;
  logic                        move_backward;
  logic                        rewinding;

  modport source (output valid, output period_count, output step_running,
                  output fast_prescale, output move_backward, output rewinding,
                  input ready);
  modport sink   (input valid, input period_count, input step_running,
                  input fast_prescale, input move_backward, input rewinding,
                  output ready);
endinterface

@@ sv/stepper_speed_ramp_controller_unit.sv @@
`timescale 1ns / 1ps
// Stepper speed ramp controller: one button sample in, one result transaction out.
// Flow: an accepted sample passes the idle, divide (only when a speed reload needs a quotient)
// and write states; the serial divider makes one quotient bit a cycle. A new sample is taken
// only once the last result is in the output register, so an undrained output holds the input.
// Reset (rst, synchronous): motor stopped, tracking mode, slow range, registers to defaults.
// Depends on sscu_pkg, sscu_if, sscu_div and sscu_ctrl.
module stepper_speed_ramp_controller_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sscu_pkg::IDX_W-1:0]    cfg_index,
  input  logic [sscu_pkg::CLK_W-1:0]    cfg_data,
  sscu_in_if.sink                       in_ch,
  sscu_out_if.source                    out_ch
);

  sscu_pkg::cfg_t     cfg;
  sscu_pkg::div_req_t div_req;
  sscu_pkg::div_rsp_t div_rsp;
  sscu_pkg::status_t  status;
  sscu_pkg::state_t   state;
  sscu_pkg::state_t   state_next;

  logic step;
  logic out_load;
  logic out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.clock_hz       <= sscu_pkg::RST_CLOCK_HZ;
      cfg.track_speed    <= sscu_pkg::RST_TRACK_SPD;
      cfg.rewind_speed   <= sscu_pkg::RST_REWIND_SPD;
      cfg.ramp_step      <= sscu_pkg::RST_RAMP_STEP;
      cfg.debounce_ticks <= sscu_pkg::RST_DEBOUNCE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sscu_pkg::CFG_CLOCK_HZ:   cfg.clock_hz       <= cfg_data;
        sscu_pkg::CFG_TRACK_SPD:  cfg.track_speed    <= cfg_data[sscu_pkg::SPEED_W-1:0];
        sscu_pkg::CFG_REWIND_SPD: cfg.rewind_speed   <= cfg_data[sscu_pkg::SPEED_W-1:0];
        sscu_pkg::CFG_RAMP_STEP:  cfg.ramp_step      <= cfg_data[sscu_pkg::SPEED_W-1:0];
        sscu_pkg::CFG_DEBOUNCE:   cfg.debounce_ticks <= cfg_data[sscu_pkg::DEB_W-1:0];
        default: ;
      endcase
    end
  end

  sscu_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .track_level  (in_ch.track_level),
    .rewind_level (in_ch.rewind_level),
    .cfg          (cfg),
    .rsp          (div_rsp),
    .req          (div_req),
    .status       (status)
  );

  sscu_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sscu_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sscu_pkg::ST_IDLE:  if (step) state_next = div_req.start ? sscu_pkg::ST_DIV
                                                               : sscu_pkg::ST_WRITE;
      sscu_pkg::ST_DIV:   if (div_rsp.done) state_next = sscu_pkg::ST_WRITE;
      sscu_pkg::ST_WRITE: if (out_load) state_next = sscu_pkg::ST_IDLE;
      default:            state_next = sscu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = (state == sscu_pkg::ST_IDLE);
    step        = in_ch.valid && (state == sscu_pkg::ST_IDLE);
    out_load    = (state == sscu_pkg::ST_WRITE) && (!out_valid || out_ch.ready);
  end

  // Output register: hold the transaction until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.period_count  <= status.count;
      out_ch.step_running  <= status.running;
      out_ch.fast_prescale <= status.range_fast;
      out_ch.move_backward <= status.dir;
      out_ch.rewinding     <= status.mode_rewind;
    end
  end

  assign out_ch.valid = out_valid;

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == sscu_pkg::ST_DIV))
    else $error("divider finished outside the divide state");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    step |=> (state != sscu_pkg::ST_IDLE))
    else $error("accepted transaction did not start processing");

  a_run_matches_count: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.step_running == (out_ch.period_count != '0)))
    else $error("step_running disagrees with period_count");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.period_count <= sscu_pkg::COUNT_W'(256)))
    else $error("period_count beyond compare range");

endmodule

@@ sv/sscu_div.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, shared by every speed reload.
// Depends on sscu_pkg.
module sscu_div (
  input  logic                clk,
  input  logic                rst,
  input  sscu_pkg::div_req_t  req,
  output sscu_pkg::div_rsp_t  rsp
);

  logic                              busy;
  logic                              done;
  logic [sscu_pkg::DCNT_W-1:0]       cnt;
  logic [sscu_pkg::SPEED_W-1:0]      rem;
  logic [sscu_pkg::SPEED_W-1:0]      dvs;
  logic [sscu_pkg::DVD_W-1:0]        quo;
  logic [sscu_pkg::SPEED_W:0]        trial;
  logic                              fits;

  always_comb begin
    trial = {rem, quo[sscu_pkg::DVD_W-1]};
    fits  = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= sscu_pkg::DCNT_W'(sscu_pkg::DIV_STEPS - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operands: dividend bits shift out the top while quotient bits enter below.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dvs <= req.divisor;
      quo <= req.dividend;
    end else if (busy) begin
      rem <= fits ? sscu_pkg::SPEED_W'(trial - {1'b0, dvs}) : trial[sscu_pkg::SPEED_W-1:0];
      quo <= {quo[sscu_pkg::DVD_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

@@ sv/sscu_ctrl.sv @@
`timescale 1ns / 1ps
// Button debounce, mode selection and speed ramp state; issues divider requests.
// Depends on sscu_pkg.
module sscu_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                track_level,
  input  logic                rewind_level,
  input  sscu_pkg::cfg_t      cfg,
  input  sscu_pkg::div_rsp_t  rsp,
  output sscu_pkg::div_req_t  req,
  output sscu_pkg::status_t   status
);

  logic [sscu_pkg::SPEED_W-1:0] speed_now;
  logic [sscu_pkg::SPEED_W-1:0] speed_goal;
  logic                         dir_now;
  logic                         dir_goal;
  logic                         slowing;
  logic                         range_fast;
  logic                         mode_rewind;
  logic [sscu_pkg::DEB_W-1:0]   hold_trk;
  logic [sscu_pkg::DEB_W-1:0]   hold_rew;
  logic                         latch_trk;
  logic                         latch_rew;
  logic [sscu_pkg::COUNT_W-1:0] count_out;
  logic                         running_out;

  logic [sscu_pkg::SPEED_W-1:0] speed_goal_next;
  logic                         dir_goal_next;
  logic                         slowing_next;
  logic                         range_fast_next;
  logic                         mode_rewind_next;
  logic [sscu_pkg::DEB_W-1:0]   hold_trk_next;
  logic [sscu_pkg::DEB_W-1:0]   hold_rew_next;
  logic                         latch_trk_next;
  logic                         latch_rew_next;
  logic                         skip_rew;
  logic                         load;
  logic [sscu_pkg::SPEED_W-1:0] load_speed;
  logic                         load_dir;
  logic [sscu_pkg::SPEED_W:0]   sum;

  always_comb begin
    hold_trk_next    = hold_trk;
    hold_rew_next    = hold_rew;
    latch_trk_next   = latch_trk;
    latch_rew_next   = latch_rew;
    speed_goal_next  = speed_goal;
    dir_goal_next    = dir_goal;
    slowing_next     = slowing;
    range_fast_next  = range_fast;
    mode_rewind_next = mode_rewind;
    skip_rew         = 1'b0;
    load             = 1'b0;
    load_speed       = speed_now;
    load_dir         = dir_now;
    sum              = {1'b0, speed_now} + {1'b0, cfg.ramp_step};

    // Track button; a change on the active mode's button ends button handling.
    if (hold_trk != '0) begin
      hold_trk_next = hold_trk - 1'b1;
    end else if (latch_trk != track_level) begin
      hold_trk_next  = cfg.debounce_ticks;
      latch_trk_next = track_level;
      if (!mode_rewind_next) begin
        skip_rew = 1'b1;
      end else if (track_level) begin
        range_fast_next  = 1'b0;
        speed_goal_next  = cfg.track_speed;
        dir_goal_next    = 1'b0;
        slowing_next     = 1'b1;
        mode_rewind_next = 1'b0;
      end
    end

    if (!skip_rew) begin
      if (hold_rew != '0) begin
        hold_rew_next = hold_rew - 1'b1;
      end else if (latch_rew != rewind_level) begin
        hold_rew_next  = cfg.debounce_ticks;
        latch_rew_next = rewind_level;
        if (!mode_rewind_next && rewind_level) begin
          range_fast_next  = 1'b1;
          speed_goal_next  = cfg.rewind_speed;
          dir_goal_next    = 1'b1;
          slowing_next     = 1'b1;
          mode_rewind_next = 1'b1;
        end
      end
    end

    // Ramp: stopped picks range and starts, slowing steps down (fast range) or stops, else climb to goal.
    if (speed_now == '0) begin
      range_fast_next = (speed_goal_next > sscu_pkg::FAST_LIMIT);
      load            = 1'b1;
      load_speed      = range_fast_next ? cfg.ramp_step : speed_goal_next;
      load_dir        = dir_goal_next;
    end else if (slowing_next) begin
      load = 1'b1;
      if (range_fast_next && (speed_now > cfg.ramp_step)) begin
        load_speed = speed_now - cfg.ramp_step;
      end else begin
        load_speed   = '0;
        slowing_next = 1'b0;
      end
    end else if (speed_now < speed_goal_next) begin
      load       = 1'b1;
      load_dir   = dir_goal_next;
      load_speed = (sum < {1'b0, speed_goal_next}) ? sum[sscu_pkg::SPEED_W-1:0]
                                                   : speed_goal_next;
    end
  end

  assign req.start    = step && load && (load_speed != '0);
  assign req.divisor  = load_speed;
  assign req.dividend = range_fast_next
                        ? cfg.clock_hz[sscu_pkg::CLK_W-1:1]
                        : sscu_pkg::DVD_W'(cfg.clock_hz[sscu_pkg::CLK_W-1:6]);

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_now   <= '0;
      speed_goal  <= '0;
      dir_now     <= 1'b0;
      dir_goal    <= 1'b0;
      slowing     <= 1'b0;
      range_fast  <= 1'b0;
      mode_rewind <= 1'b0;
      hold_trk    <= '0;
      hold_rew    <= '0;
      latch_trk   <= 1'b0;
      latch_rew   <= 1'b0;
      count_out   <= '0;
      running_out <= 1'b0;
    end else if (step) begin
      speed_goal  <= speed_goal_next;
      dir_goal    <= dir_goal_next;
      slowing     <= slowing_next;
      range_fast  <= range_fast_next;
      mode_rewind <= mode_rewind_next;
      hold_trk    <= hold_trk_next;
      hold_rew    <= hold_rew_next;
      latch_trk   <= latch_trk_next;
      latch_rew   <= latch_rew_next;
      if (load) begin
        speed_now <= load_speed;
        dir_now   <= load_dir;
        if (load_speed == '0) begin
          count_out   <= '0;
          running_out <= 1'b0;
        end
      end
    end else if (rsp.done) begin
      // Stop when the quotient is zero or too large for the compare register.
      if ((rsp.quotient == '0) || (rsp.quotient[sscu_pkg::DVD_W-1:8] != '0)) begin
        count_out   <= '0;
        running_out <= 1'b0;
      end else begin
        count_out   <= {1'b0, rsp.quotient[7:0]} + sscu_pkg::COUNT_W'(1);
        running_out <= 1'b1;
      end
    end
  end

  assign status.count       = count_out;
  assign status.running     = running_out;
  assign status.range_fast  = range_fast;
  assign status.dir         = dir_now;
  assign status.mode_rewind = mode_rewind;

endmodule
